FILE: rtl/omcm_pkg.sv
package omcm_pkg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_ALIGN  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam logic signed [20:0] PI_Q     = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q = 21'sd411775;
    localparam logic signed [32:0] S33_MAX  = {1'b0, {32{1'b1}}};
    localparam logic signed [32:0] S33_MIN  = {1'b1, {32{1'b0}}};

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word, do start/align work
        logic sq_start;  // launch the squaring and root
        logic finish;    // apply sample step
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sample;
        logic sq_busy;
    } dp_sts_t;

endpackage

FILE: rtl/odometry_move_completion_monitor.sv
// odometry move completion monitor
// s_ channel: one command word per transfer; s_tuser carries func
// (0 odometry sample, 1 start move, 2 align to heading, 3 no-op).
// m_ channel: one result word per command, holding the linear and angular
// speed commands now held and a done flag in m_tuser.
// start, align and no-op words give their result in the cycle after acceptance.
// an odometry sample gives its result after the deltas, the squares, the
// loading of the root unit, the bit-serial square root of the 64-bit sum
// and the update of the remaining amounts, each registered in that order.
// one word is in flight at a time; the next word is accepted in the cycle
// after the result is taken, so a stalled receiver holds the block.
// the result stays stable on m_ while m_tready is low.
// reset (aresetn low, synchronous) clears the pose, remaining amounts and
// held speeds to zero and empties the block.
module odometry_move_completion_monitor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pose_yaw, distance, lin_speed, rotation, rot_speed,
    // target_heading, zero fill to 208 bits
    input  logic [207:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // lin_cmd, ang_cmd, zero fill
    output logic [39:0]  m_tdata,
    // done_res
    output logic         m_tuser
);

    omcm_pkg::dp_cmd_t cmd;
    omcm_pkg::dp_sts_t sts;
    logic [17:0] lin_cmd, ang_cmd;

    omcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    omcm_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .func           (s_tuser),
        .pos_x          (s_tdata[31:0]),
        .pos_y          (s_tdata[63:32]),
        .pose_yaw       (s_tdata[82:64]),
        .distance       (s_tdata[114:83]),
        .lin_speed      (s_tdata[132:115]),
        .rotation       (s_tdata[164:133]),
        .rot_speed      (s_tdata[182:165]),
        .target_heading (s_tdata[201:183]),
        .lin_cmd        (lin_cmd),
        .ang_cmd        (ang_cmd),
        .done_res       (m_tuser)
    );

    assign m_tdata = {4'd0, ang_cmd, lin_cmd};

endmodule

FILE: rtl/omcm_isqrt.sv
module omcm_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] val_reg, val_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [65:0] trial;
    logic [65:0] shifted;

    // restoring square root, one result bit a cycle
    always_comb begin
        shifted   = {rem_reg, val_reg[63:62]};
        trial     = shifted - {32'd0, root_reg, 2'b01};
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            root_next = '0;
            val_next  = radicand;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[61:0], 2'b00};
            if (!trial[65]) begin
                rem_next  = trial[63:0];
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = shifted[63:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

FILE: rtl/omcm_datapath.sv
module omcm_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  omcm_pkg::dp_cmd_t cmd,
    output omcm_pkg::dp_sts_t sts,
    input  logic [1:0]        func,
    input  logic [31:0]       pos_x,
    input  logic [31:0]       pos_y,
    input  logic [18:0]       pose_yaw,
    input  logic [31:0]       distance,
    input  logic [17:0]       lin_speed,
    input  logic [31:0]       rotation,
    input  logic [17:0]       rot_speed,
    input  logic [18:0]       target_heading,
    output logic [17:0]       lin_cmd,
    output logic [17:0]       ang_cmd,
    output logic              done_res
);

    logic signed [31:0] cur_x_reg, cur_y_reg, last_x_reg, last_y_reg;
    logic signed [18:0] cur_yaw_reg, last_yaw_reg;
    logic signed [32:0] dist_left_reg, turn_left_reg;
    logic signed [17:0] lin_hold_reg, ang_hold_reg;
    logic               done_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic [63:0]        sx2_reg, sy2_reg;
    logic               sq_busy;
    logic [31:0]        root;
    logic [1:0]         sqp_reg;

    // start and align
    logic signed [32:0] dist_abs, rot_abs;
    logic signed [20:0] hd, yw, fwd, bwd, fwd_mag, bwd_mag;
    logic signed [18:0] neg_spd;

    always_comb begin
        dist_abs = $signed(distance[31]) ? -$signed({distance[31], distance})
                                         : $signed({distance[31], distance});
        rot_abs  = $signed(rotation[31]) ? -$signed({rotation[31], rotation})
                                         : $signed({rotation[31], rotation});
        hd  = 21'($signed(target_heading));
        yw  = 21'(cur_yaw_reg);
        fwd = ((hd < yw) ? hd + omcm_pkg::TWO_PI_Q : hd) - yw;
        bwd = yw - ((hd > yw) ? hd - omcm_pkg::TWO_PI_Q : hd);
        // a turn can come out negative when the two headings are far apart
        fwd_mag = fwd[20] ? -fwd : fwd;
        bwd_mag = bwd[20] ? -bwd : bwd;
        neg_spd = -19'($signed(rot_speed));
        if (neg_spd > 19'sd131071) begin
            neg_spd = 19'sd131071;
        end
    end

    // sample step
    logic [64:0]        sqsum;
    logic [63:0]        radicand;
    logic signed [33:0] dnew, tnew;
    logic signed [20:0] ydiff, ac, al;
    logic signed [32:0] dsat, tsat;

    always_comb begin
        sqsum    = {1'b0, sx2_reg} + {1'b0, sy2_reg};
        radicand = sqsum[64] ? {64{1'b1}} : sqsum[63:0];
        dnew = 34'(dist_left_reg) - 34'($signed({1'b0, root}));
        dsat = (dnew > 34'(omcm_pkg::S33_MAX)) ? omcm_pkg::S33_MAX :
               (dnew < 34'(omcm_pkg::S33_MIN)) ? omcm_pkg::S33_MIN : dnew[32:0];
        ac = cur_yaw_reg[18] ? -21'(cur_yaw_reg) : 21'(cur_yaw_reg);
        al = last_yaw_reg[18] ? -21'(last_yaw_reg) : 21'(last_yaw_reg);
        ydiff = 21'(cur_yaw_reg) - 21'(last_yaw_reg);
        if (ydiff[20]) begin
            ydiff = -ydiff;
        end
        if (ydiff > omcm_pkg::PI_Q) begin
            ydiff = (omcm_pkg::PI_Q - ac) + (omcm_pkg::PI_Q - al);
        end
        tnew = 34'(turn_left_reg) - 34'(ydiff);
        tsat = (tnew > 34'(omcm_pkg::S33_MAX)) ? omcm_pkg::S33_MAX :
               (tnew < 34'(omcm_pkg::S33_MIN)) ? omcm_pkg::S33_MIN : tnew[32:0];
    end

    logic signed [32:0] dx, dy;
    always_comb begin
        dx = 33'(cur_x_reg) - 33'(last_x_reg);
        dy = 33'(cur_y_reg) - 33'(last_y_reg);
    end

    omcm_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqp_reg[1]),
        .radicand (radicand),
        .busy     (sq_busy),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_yaw_reg   <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_yaw_reg  <= '0;
            dist_left_reg <= '0;
            turn_left_reg <= '0;
            lin_hold_reg  <= '0;
            ang_hold_reg  <= '0;
            done_reg      <= 1'b0;
            sqp_reg       <= '0;
        end else begin
            // abs, then squares, then root start
            sqp_reg <= {sqp_reg[0], cmd.sq_start};
            if (cmd.sq_start) begin
                ax_reg <= dx[32] ? 32'(-dx) : dx[31:0];
                ay_reg <= dy[32] ? 32'(-dy) : dy[31:0];
            end
            if (sqp_reg[0]) begin
                sx2_reg <= ax_reg * ax_reg;
                sy2_reg <= ay_reg * ay_reg;
            end
            if (cmd.load) begin
                done_reg <= 1'b0;
                unique case (omcm_pkg::func_t'(func))
                    omcm_pkg::FUNC_SAMPLE: begin
                        cur_x_reg   <= pos_x;
                        cur_y_reg   <= pos_y;
                        cur_yaw_reg <= pose_yaw;
                    end
                    omcm_pkg::FUNC_START: begin
                        dist_left_reg <= dist_abs;
                        turn_left_reg <= rot_abs;
                        last_x_reg    <= cur_x_reg;
                        last_y_reg    <= cur_y_reg;
                        last_yaw_reg  <= cur_yaw_reg;
                        lin_hold_reg  <= lin_speed;
                        ang_hold_reg  <= rot_speed;
                    end
                    omcm_pkg::FUNC_ALIGN: begin
                        dist_left_reg <= '0;
                        last_x_reg    <= cur_x_reg;
                        last_y_reg    <= cur_y_reg;
                        last_yaw_reg  <= cur_yaw_reg;
                        lin_hold_reg  <= '0;
                        if (bwd < fwd) begin
                            turn_left_reg <= 33'(bwd_mag);
                            ang_hold_reg  <= neg_spd[17:0];
                        end else begin
                            turn_left_reg <= 33'(fwd_mag);
                            ang_hold_reg  <= rot_speed;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.finish) begin
                last_x_reg    <= cur_x_reg;
                last_y_reg    <= cur_y_reg;
                last_yaw_reg  <= cur_yaw_reg;
                dist_left_reg <= dsat;
                turn_left_reg <= tsat;
                done_reg <= (dsat <= 0 || lin_hold_reg == '0) &&
                            (tsat <= 0 || ang_hold_reg == '0);
                if (dsat <= 0) begin
                    lin_hold_reg <= '0;
                end
                if (tsat <= 0) begin
                    ang_hold_reg <= '0;
                end
            end
        end
    end

    assign sts.is_sample = (omcm_pkg::func_t'(func) == omcm_pkg::FUNC_SAMPLE);
    assign sts.sq_busy   = sq_busy || (sqp_reg != 2'b00);
    assign lin_cmd  = lin_hold_reg;
    assign ang_cmd  = ang_hold_reg;
    assign done_res = done_reg;

endmodule

FILE: rtl/omcm_ctrl.sv
module omcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output omcm_pkg::dp_cmd_t cmd,
    input  omcm_pkg::dp_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SQ   = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.sq_start = 1'b0;
        cmd.finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = sts.is_sample ? ST_SQ : ST_OUT;
                end
            end
            ST_SQ: begin
                cmd.sq_start = 1'b1;
                state_next   = ST_WAIT;
            end
            ST_WAIT: begin
                if (!sts.sq_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct {
        omcm_pkg::func_t    func;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [18:0] yaw;
        logic signed [31:0] travel;
        logic signed [17:0] lsp;
        logic signed [31:0] rot;
        logic signed [17:0] rsp;
        logic signed [18:0] hdg;
    } cmd_t;

    typedef struct {
        logic signed [17:0] lin;
        logic signed [17:0] ang;
        logic               done;
    } speeds_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tuser;

    odometry_move_completion_monitor uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // tracked move state
    logic signed [31:0] pose_x, pose_y, prev_x, prev_y;
    logic signed [18:0] pose_yaw, prev_yaw;
    longint             dist_to_go, turn_to_go;
    logic signed [17:0] lin_held, ang_held;

    cmd_t    cmd_list[$];
    bit      typed_list[$];
    speeds_t typed_res[$];
    speeds_t speeds_due[$];
    int      mismatches = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sat33(input longint v);
        if (v > 64'sd4294967295) return 64'sd4294967295;
        if (v < -64'sd4294967296) return -64'sd4294967296;
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic void begin_move(input longint d, input logic signed [17:0] ls,
                                       input longint rt, input logic signed [17:0] as);
        dist_to_go = sat33(mag(d));
        turn_to_go = sat33(mag(rt));
        prev_x = pose_x;
        prev_y = pose_y;
        prev_yaw = pose_yaw;
        lin_held = ls;
        ang_held = as;
    endfunction

    function automatic speeds_t track_move(input cmd_t c);
        speeds_t     r;
        logic [63:0] ax, ay, sx, sy;
        logic [64:0] sum;
        longint      step, ydiff, hd, yw, t, fwd, bwd, neg;
        r.done = 0;
        case (c.func)
            omcm_pkg::FUNC_SAMPLE: begin
                pose_x = c.x;
                pose_y = c.y;
                pose_yaw = c.yaw;
                ax = mag(longint'(pose_x) - longint'(prev_x));
                ay = mag(longint'(pose_y) - longint'(prev_y));
                sx = ax * ax;
                sy = ay * ay;
                sum = {1'b0, sx} + {1'b0, sy};
                step = int_sqrt(sum[64] ? '1 : sum[63:0]);
                prev_x = pose_x;
                prev_y = pose_y;
                dist_to_go = sat33(dist_to_go - step);
                if (dist_to_go <= 0) lin_held = 0;
                ydiff = mag(longint'(pose_yaw) - longint'(prev_yaw));
                if (ydiff > 205887)
                    ydiff = (205887 - mag(longint'(pose_yaw))) + (205887 - mag(longint'(prev_yaw)));
                turn_to_go = sat33(turn_to_go - ydiff);
                if (turn_to_go <= 0) ang_held = 0;
                prev_yaw = pose_yaw;
                r.done = (lin_held == 0 && ang_held == 0);
            end
            omcm_pkg::FUNC_START:
                begin_move(longint'(c.travel), c.lsp, longint'(c.rot), c.rsp);
            omcm_pkg::FUNC_ALIGN: begin
                hd = c.hdg;
                yw = pose_yaw;
                t = (hd < yw) ? hd + 411775 : hd;
                fwd = t - yw;
                t = (hd > yw) ? hd - 411775 : hd;
                bwd = yw - t;
                if (bwd < fwd) begin
                    neg = -longint'(c.rsp);
                    if (neg > 131071) neg = 131071;
                    begin_move(0, 0, bwd, neg[17:0]);
                end else begin
                    begin_move(0, 0, fwd, c.rsp);
                end
            end
            default: ;
        endcase
        r.lin = lin_held;
        r.ang = ang_held;
        return r;
    endfunction

    function automatic cmd_t mk(input omcm_pkg::func_t f, input longint x = 0,
                                input longint y = 0, input longint yaw = 0,
                                input longint travel = 0, input longint lsp = 0,
                                input longint rot = 0, input longint rsp = 0,
                                input longint hdg = 0);
        cmd_t c;
        c.func = f; c.x = x; c.y = y; c.yaw = yaw; c.travel = travel;
        c.lsp = lsp; c.rot = rot; c.rsp = rsp; c.hdg = hdg;
        return c;
    endfunction

    function automatic void add(input cmd_t c, input bit typed = 0,
                                input longint lin = 0, input longint ang = 0,
                                input bit done = 0);
        speeds_t r;
        r.lin = lin; r.ang = ang; r.done = done;
        cmd_list.push_back(c);
        typed_list.push_back(typed);
        typed_res.push_back(r);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.func = omcm_pkg::func_t'($urandom_range(0, 3));
        c.x = $urandom; c.y = $urandom; c.yaw = $urandom; c.travel = $urandom;
        c.lsp = $urandom; c.rot = $urandom; c.rsp = $urandom; c.hdg = $urandom;
        return c;
    endfunction

    task automatic build_stimulus();
        longint wx, wy, wyaw;
        int     n, k;
        cmd_t   c;
        // reset state, extremes, wrap and saturation cases
        add(mk(omcm_pkg::FUNC_SAMPLE), 1, 0, 0, 1);
        add(mk(omcm_pkg::FUNC_START, 0, 0, 0, 65536, 65536, 0, 0), 1, 65536, 0, 0);
        add(mk(omcm_pkg::FUNC_NONE), 1, 65536, 0, 0);
        add(mk(omcm_pkg::FUNC_SAMPLE, 2147483647, -2147483648, 0), 1, 0, 0, 1);
        add(mk(omcm_pkg::FUNC_START, 0, 0, 0, -2147483648, -65536, -2147483648, -65536),
            1, -65536, -65536, 0);
        add(mk(omcm_pkg::FUNC_SAMPLE, 2147483647, -2147483648, 205888));
        add(mk(omcm_pkg::FUNC_SAMPLE, -2147483648, 2147483647, -205888));
        add(mk(omcm_pkg::FUNC_ALIGN, 0, 0, 0, 0, 0, 0, -131072, 205888));
        add(mk(omcm_pkg::FUNC_ALIGN, 0, 0, 0, 0, 0, 0, 131071, -205888));
        add(mk(omcm_pkg::FUNC_SAMPLE, 0, 0, 100000));
        add(mk(omcm_pkg::FUNC_ALIGN, 0, 0, 0, 0, 0, 0, -131072, -100000));
        add(mk(omcm_pkg::FUNC_SAMPLE, 0, 0, -100000));
        add(mk(omcm_pkg::FUNC_START, 0, 0, 0, 2147483647, 131071, 2147483647, -131072));
        add(mk(omcm_pkg::FUNC_START, 0, 0, 0, 2147483647, 131071, 2147483647, -131072));
        add(mk(omcm_pkg::FUNC_SAMPLE, 0, 0, -262144));
        add(mk(omcm_pkg::FUNC_SAMPLE, 0, 0, 262143));
        add(mk(omcm_pkg::FUNC_SAMPLE, 65536, 65536, 0));
        add(mk(omcm_pkg::FUNC_NONE, -1, -1, -1, -1, -1, -1, -1, -1));
        add(mk(omcm_pkg::FUNC_START, 0, 0, 0, 0, 1000, 0, 2000));
        add(mk(omcm_pkg::FUNC_SAMPLE, 65536, 65536, 0));
        // random moves: a random word, or a start or align then a walk of one to twelve samples
        wx = 0; wy = 0; wyaw = 0;
        while (cmd_list.size() < 1100) begin
            if ($urandom_range(0, 9) == 0) begin
                add(random_cmd());
                continue;
            end
            if ($urandom_range(0, 2) == 0)
                c = mk(omcm_pkg::FUNC_ALIGN, 0, 0, 0, 0, 0, 0, $signed(18'($urandom)),
                       $urandom_range(0, 411776) - 205888);
            else
                c = mk(omcm_pkg::FUNC_START, 0, 0, 0, $urandom_range(0, 600000) - 300000,
                       $signed(18'($urandom)), $urandom_range(0, 600000) - 300000,
                       $signed(18'($urandom)));
            add(c);
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                wx += $urandom_range(0, 80000) - 40000;
                wy += $urandom_range(0, 80000) - 40000;
                wyaw += $urandom_range(0, 80000) - 40000;
                if (wyaw > 205888) wyaw -= 411776;
                if (wyaw < -205888) wyaw += 411776;
                add(mk(omcm_pkg::FUNC_SAMPLE, wx, wy, wyaw));
            end
        end
    endtask

    initial begin
        int burst;
        cmd_t c;
        speeds_t r;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        pose_x = 0; pose_y = 0; pose_yaw = 0;
        prev_x = 0; prev_y = 0; prev_yaw = 0;
        dist_to_go = 0; turn_to_go = 0; lin_held = 0; ang_held = 0;
        build_stimulus();
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        burst = 0;
        foreach (cmd_list[i]) begin
            c = cmd_list[i];
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) begin
                    s_tvalid <= 0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end
            end
            s_tvalid <= 1;
            s_tuser <= c.func;
            s_tdata <= {6'b0, c.hdg, c.rsp, c.rot, c.lsp, c.travel, c.yaw, c.y, c.x};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            r = track_move(c);
            speeds_due.push_back(typed_list[i] ? typed_res[i] : r);
            burst--;
        end
        s_tvalid <= 0;
        while (speeds_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0)
            $display("** odometry_move_completion_monitor: PASSED **");
        else
            $display("** odometry_move_completion_monitor: FAILED **");
        $finish;
    end

    // receiver stalls: one of four m_tready patterns, chosen anew at random at regular intervals
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= (stall_cnt % 4 == 0);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    initial m_tready = 0;

    always @(posedge aclk) begin
        speeds_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (speeds_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word lin=%0d ang=%0d done=%0b",
                    $signed(m_tdata[17:0]), $signed(m_tdata[35:18]), m_tuser);
            end else begin
                e = speeds_due.pop_front();
                if (m_tdata[17:0] !== e.lin || m_tdata[35:18] !== e.ang
                        || m_tuser !== e.done || m_tdata[39:36] !== 4'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected lin=%0d ang=%0d done=%0b, got lin=%0d ang=%0d done=%0b",
                            e.lin, e.ang, e.done, $signed(m_tdata[17:0]),
                            $signed(m_tdata[35:18]), m_tuser);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("** odometry_move_completion_monitor: FAILED **");
        $finish;
    end

endmodule
